// ===== sv/sha1_hash_macros.svh =====
// ----------------------------------------------------------------------------
// SHA-1 hasher assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SHA1_HASH_MACROS_SVH
`define SHA1_HASH_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define SHA1_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition in one cycle that forces a condition in the next one.
`define SHA1_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define SHA1_ASSERT(label, prop, msg)
`define SHA1_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== sv/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hasher package
// Types, round constants and sequencing codes shared by the hasher modules.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int BLOCK_BITS   = 512;
  localparam int DIGEST_BITS  = 160;
  localparam int DIGEST_BYTES = 20;

  // Initial chaining value.
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  // Round constants, one for each group of twenty rounds.
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [6:0] ROUND_GROUP1 = 7'd20;
  localparam logic [6:0] ROUND_GROUP2 = 7'd40;
  localparam logic [6:0] ROUND_GROUP3 = 7'd60;
  localparam logic [6:0] LAST_ROUND   = 7'd79;

  localparam logic [7:0] PAD_BYTE       = 8'h80;
  localparam logic [5:0] FILL_LAST      = 6'd63;
  localparam logic [5:0] FILL_PAD_END   = 6'd55;
  localparam logic [5:0] FILL_LEN_START = 6'd56;
  localparam logic [4:0] LAST_OUT       = 5'd19;

  // One queued command: a message byte, an end mark, or both.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } cmd_t;

  // Requests from the sequencer to the compression unit.
  typedef struct packed {
    logic start;
    logic iv_load;
  } core_ctrl_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_RUN,
    CORE_FOLD
  } core_state_t;

  typedef enum logic [2:0] {
    ST_ABSORB,
    ST_PAD80,
    ST_PADZ,
    ST_LEN,
    ST_WAIT,
    ST_OUT
  } back_state_t;

endpackage

// ===== sv/sha1_front.sv =====
// ----------------------------------------------------------------------------
// SHA-1 front end
// Accepts input items, drops idle ones and queues the rest for the sequencer.
// ----------------------------------------------------------------------------
module sha1_front
  import sha1_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       byte_valid,
  input  logic       end_of_message,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             queue [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr_en;
  logic             rd_en;

  assign full      = (count == CNT_W'(DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];

  // An item with neither a byte nor an end mark is taken and dropped here.
  assign wr_en = push && !full && (byte_valid || end_of_message);
  assign rd_en = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue[wr_ptr] <= '{data_byte: data_byte, byte_valid: byte_valid,
                         end_of_message: end_of_message};
    end
  end

endmodule

// ===== sv/sha1_core.sv =====
// ----------------------------------------------------------------------------
// SHA-1 compression unit
// Runs the 80 rounds of one block, one round per cycle, and holds the chain.
// ----------------------------------------------------------------------------
`include "sha1_hash_macros.svh"

module sha1_core
  import sha1_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  core_ctrl_t             ctrl,
  input  logic [BLOCK_BITS-1:0]  block,
  output logic                   busy,
  output logic [DIGEST_BITS-1:0] digest
);

  core_state_t state;
  core_state_t state_next;

  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [31:0] sched [16];
  logic [6:0]  round;
  logic [31:0] mix;
  logic [31:0] w_new;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] temp;

  assign digest = {h[0], h[1], h[2], h[3], h[4]};

  always_comb begin
    state_next = state;
    case (state)
      CORE_IDLE: if (ctrl.start) state_next = CORE_RUN;
      CORE_RUN:  if (round == LAST_ROUND) state_next = CORE_FOLD;
      CORE_FOLD: state_next = CORE_IDLE;
      default:   state_next = CORE_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != CORE_IDLE);
  end

  // The schedule is a sliding window: sched[0] is always the word of this round.
  always_comb begin
    mix   = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
    w_new = {mix[30:0], mix[31]};
    if (round < ROUND_GROUP1) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (round < ROUND_GROUP2) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (round < ROUND_GROUP3) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    temp = {a[26:0], a[31:27]} + f + e + k + sched[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORE_IDLE;
      round <= '0;
      h[0]  <= IV0;
      h[1]  <= IV1;
      h[2]  <= IV2;
      h[3]  <= IV3;
      h[4]  <= IV4;
    end else begin
      state <= state_next;
      if (state == CORE_RUN) begin
        round <= round + 7'd1;
      end else begin
        round <= '0;
      end
      if (ctrl.iv_load) begin
        h[0] <= IV0;
        h[1] <= IV1;
        h[2] <= IV2;
        h[3] <= IV3;
        h[4] <= IV4;
      end else if (state == CORE_FOLD) begin
        h[0] <= h[0] + a;
        h[1] <= h[1] + b;
        h[2] <= h[2] + c;
        h[3] <= h[3] + d;
        h[4] <= h[4] + e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == CORE_IDLE && ctrl.start) begin
      for (int j = 0; j < 16; j++) begin
        sched[j] <= block[BLOCK_BITS-1-32*j -: 32];
      end
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (state == CORE_RUN) begin
      for (int j = 0; j < 15; j++) begin
        sched[j] <= sched[j+1];
      end
      sched[15] <= w_new;
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= temp;
    end
  end

  `SHA1_ASSERT(a_start_when_idle, !ctrl.start || (state == CORE_IDLE), "block start while busy")
  `SHA1_ASSERT(a_iv_when_idle, !ctrl.iv_load || (state == CORE_IDLE), "chain reload while busy")
  `SHA1_ASSERT_NEXT(a_fold_after_last, (state == CORE_RUN) && (round == LAST_ROUND), state == CORE_FOLD, "no fold after the last round")

endmodule

// ===== sv/sha1_back.sv =====
// ----------------------------------------------------------------------------
// SHA-1 sequencer
// Packs bytes into the block buffer, pads the message and emits the digest.
// ----------------------------------------------------------------------------
`include "sha1_hash_macros.svh"

module sha1_back
  import sha1_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  input  cmd_t                   cmd,
  output logic                   cmd_pop,
  output core_ctrl_t             core_ctrl,
  output logic [BLOCK_BITS-1:0]  core_block,
  input  logic                   core_busy,
  input  logic [DIGEST_BITS-1:0] digest,
  output logic [7:0]             digest_byte,
  output logic                   digest_last,
  output logic                   empty,
  input  logic                   pop
);

  back_state_t state;
  back_state_t state_next;

  logic [BLOCK_BITS-1:0] block_buf;
  logic [5:0]            fill;
  logic [63:0]           bit_length;
  logic [4:0]            out_cnt;
  logic                  out_valid;
  logic                  put_ok;
  logic                  put_en;
  logic [7:0]            put_data;
  logic                  len_add;
  logic                  slot_free;
  logic                  out_load;
  logic                  msg_done;
  logic [7:0][7:0]       len_bytes;
  logic [DIGEST_BYTES-1:0][7:0] dig_bytes;

  assign len_bytes  = bit_length;
  assign dig_bytes  = digest;
  assign empty      = !out_valid;
  assign slot_free  = !out_valid || pop;
  // The byte that completes a block must wait until the compressor is free.
  assign put_ok     = !((fill == FILL_LAST) && core_busy);
  assign core_block = {block_buf[BLOCK_BITS-9:0], put_data};

  always_comb begin
    state_next = state;
    case (state)
      ST_ABSORB: begin
        if (cmd_valid && (!cmd.byte_valid || put_ok) && cmd.end_of_message) begin
          state_next = ST_PAD80;
        end
      end
      ST_PAD80: begin
        if (put_ok) state_next = (fill == FILL_PAD_END) ? ST_LEN : ST_PADZ;
      end
      ST_PADZ: begin
        if (put_ok && (fill == FILL_PAD_END)) state_next = ST_LEN;
      end
      ST_LEN: begin
        if (put_ok && (fill == FILL_LAST)) state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (!core_busy) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (slot_free && (out_cnt == LAST_OUT)) state_next = ST_ABSORB;
      end
      default: state_next = ST_ABSORB;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    put_en   = 1'b0;
    put_data = '0;
    len_add  = 1'b0;
    out_load = 1'b0;
    msg_done = 1'b0;
    case (state)
      ST_ABSORB: begin
        cmd_pop  = cmd_valid && (!cmd.byte_valid || put_ok);
        put_en   = cmd_pop && cmd.byte_valid;
        put_data = cmd.data_byte;
        len_add  = put_en;
      end
      ST_PAD80: begin
        put_en   = put_ok;
        put_data = PAD_BYTE;
      end
      ST_PADZ: begin
        put_en = put_ok;
      end
      ST_LEN: begin
        put_en   = put_ok;
        put_data = len_bytes[~fill[2:0]];
      end
      ST_OUT: begin
        out_load = slot_free;
        msg_done = slot_free && (out_cnt == LAST_OUT);
      end
      default: begin
        put_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    core_ctrl.start   = put_en && (fill == FILL_LAST);
    core_ctrl.iv_load = msg_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_ABSORB;
      fill       <= '0;
      bit_length <= '0;
      out_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (put_en) begin
        fill <= fill + 6'd1;
      end
      if (msg_done) begin
        bit_length <= '0;
      end else if (len_add) begin
        bit_length <= bit_length + 64'd8;
      end
      if (state == ST_WAIT) begin
        out_cnt <= '0;
      end else if (out_load) begin
        out_cnt <= out_cnt + 5'd1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (put_en) begin
      block_buf <= core_block;
    end
    if (out_load) begin
      digest_byte <= dig_bytes[5'(DIGEST_BYTES - 1) - out_cnt];
      digest_last <= (out_cnt == LAST_OUT);
    end
  end

  `SHA1_ASSERT(a_len_in_tail, (state != ST_LEN) || (fill >= FILL_LEN_START), "length bytes outside the block tail")
  `SHA1_ASSERT(a_out_core_idle, (state != ST_OUT) || !core_busy, "digest read while compressing")
  `SHA1_ASSERT_NEXT(a_msg_cleared, msg_done, (bit_length == 64'd0) && (fill == 6'd0), "message state not cleared")

endmodule

// ===== sv/sha1_hash.sv =====
// ----------------------------------------------------------------------------
// SHA-1 streaming hasher
// Hashes a byte stream and returns the 20-byte digest after each message.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake      Payload
// input     in         push / full    data_byte, byte_valid, end_of_message
// result    out        pop / empty    digest_byte, digest_last
//
// The sequencer packs message bytes one at a time. A full block starts a
// compression (80 rounds and a chaining add), during which the next block
// keeps filling. The byte that closes the next block is handed over once the
// chaining add is done, so long messages overlap filling and compression.
// The end of a message costs 9 to 72 padding bytes, the wait for the last
// compression and the 20 digest bytes.
// Reset is synchronous and returns the chain to the initial vector at once.
// full rises when the input queue holds QUEUE_DEPTH items; the sequencer
// stalls when a block completes while the compressor is still busy, or when
// a digest byte is not popped.
//
// Structure: the front end takes every transfer, drops items that carry
// neither a byte nor an end mark, and queues the rest. The sequencer packs
// bytes into a 64-byte shift buffer, appends the padding and bit length,
// hands each full block to the compression unit and streams the digest out
// through an output register. The compression unit keeps its own copy of the
// block as a sliding 16-word schedule window, so the buffer is free again as
// soon as a block is handed over.
// ----------------------------------------------------------------------------
module sha1_hash
  import sha1_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       byte_valid,
  input  logic       end_of_message,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] digest_byte,
  output logic       digest_last
);

  logic                   cmd_valid;
  cmd_t                   cmd;
  logic                   cmd_pop;
  core_ctrl_t             core_ctrl;
  logic [BLOCK_BITS-1:0]  core_block;
  logic                   core_busy;
  logic [DIGEST_BITS-1:0] digest;

  // Input queue; idle items are taken here and never reach the sequencer.
  sha1_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .byte_valid    (byte_valid),
    .end_of_message(end_of_message),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  // Byte packing, padding and digest output.
  sha1_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .core_ctrl  (core_ctrl),
    .core_block (core_block),
    .core_busy  (core_busy),
    .digest     (digest),
    .digest_byte(digest_byte),
    .digest_last(digest_last),
    .empty      (empty),
    .pop        (pop)
  );

  // Round engine and chaining words.
  sha1_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (core_ctrl),
    .block (core_block),
    .busy  (core_busy),
    .digest(digest)
  );

endmodule
